// File: rtl/core/lcdc_pkg.sv
// Package: shared constants, codes and address helper for the LCD controller display RAM.
`timescale 1ns / 1ps
`default_nettype none

package lcdc_pkg;

    // Display geometry.
    localparam int ROWS      = 64;
    localparam int ROW_BYTES = 15;
    localparam int RAM_DEPTH = ROWS * ROW_BYTES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = 5;
    localparam int IDX_W     = 5;

    // Access codes carried in the op field.
    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_STATUS = 3'd3;
    localparam logic [2:0] OP_PIXEL  = 3'd4;

    // Cursor auto-advance modes.
    localparam logic [1:0] ADV_ROW_DEC = 2'd0;
    localparam logic [1:0] ADV_ROW_INC = 2'd1;
    localparam logic [1:0] ADV_COL_DEC = 2'd2;
    localparam logic [1:0] ADV_COL_INC = 2'd3;

    // Last cursor column in 8-bit and 6-bit word mode.
    localparam logic [COL_W-1:0] LAST_COL_BYTE  = 5'd14;
    localparam logic [COL_W-1:0] LAST_COL_WORD6 = 5'd19;

    // Bit position of the 6-bit word inside the two fetched bytes.
    localparam logic [3:0]  WORD6_SHIFT_BASE = 4'd10;
    localparam logic [15:0] WORD6_MASK       = 16'h003f;

    // Byte address of one row byte: row * 15 + idx.
    function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row,
                                                   input logic [3:0] idx);
        logic [ADDR_W-1:0] base;
        base = {row, 4'b0000} - {{(ADDR_W-ROW_W){1'b0}}, row};
        return base + {{(ADDR_W-4){1'b0}}, idx};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcd_controller_display_ram.sv
// Top level: monochrome LCD controller with a 64-row by 15-byte display RAM.
// Sequencing: commands and status reads go S_IDLE, S_COMMIT; pixel queries and 8-bit
// data accesses pass S_FETCH1 first, 6-bit ones S_FETCH1 and S_FETCH2. S_COMMIT waits
// while the output is stalled. A request is taken only in S_IDLE, once the last is done;
// a 6-bit write that spans two bytes adds S_WRITE2 for its second RAM write through the single write port.
// Reset: asynchronous; a clearing pass then zeroes all 960 bytes of the display RAM.
`timescale 1ns / 1ps
`default_nettype none

module lcd_controller_display_ram (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: op[2:0], bus_value[10:3], query_row[16:11], query_column[23:17]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: read_data[7:0], pixel_on[8], display_enabled[9], zero[15:10]
    output logic      [15:0] m_tdata
);

    import lcdc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH1,
        S_FETCH2,
        S_COMMIT,
        S_WRITE2
    } state_t;

    // Registers.
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [2:0]        item_op_reg, item_op_next;
    logic [7:0]        item_value_reg, item_value_next;
    logic [6:0]        item_qcol_reg, item_qcol_next;
    logic [7:0]        byte0_reg, byte0_next;
    logic [7:0]        byte1_reg, byte1_next;
    logic [ADDR_W-1:0] wr2_addr_reg, wr2_addr_next;
    logic [7:0]        wr2_data_reg, wr2_data_next;
    logic              enable_reg, enable_next;
    logic [1:0]        advance_reg, advance_next;
    logic [ROW_W-1:0]  scroll_reg, scroll_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic              dummy_reg, dummy_next;
    logic              byte_mode_reg, byte_mode_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_pixel_reg, out_pixel_next;
    logic              out_enable_reg, out_enable_next;

    // RAM port signals.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Incoming request fields.
    logic [2:0]       in_op;
    logic [7:0]       in_value;
    logic [ROW_W-1:0] in_qrow;
    logic [6:0]       in_qcol;

    assign in_op    = s_tdata[2:0];
    assign in_value = s_tdata[10:3];
    assign in_qrow  = s_tdata[16:11];
    assign in_qcol  = s_tdata[23:17];

    // Location of the word under the cursor.
    logic [7:0]        bitpos;
    logic [IDX_W-1:0]  data_idx;
    logic              data_valid;
    logic              next_valid;
    logic [ADDR_W-1:0] data_addr0;
    logic [ADDR_W-1:0] data_addr1;
    logic [3:0]        shift;

    assign bitpos     = ({3'b000, cursor_col_reg} << 2) + ({3'b000, cursor_col_reg} << 1);
    assign data_idx   = byte_mode_reg ? cursor_col_reg : bitpos[7:3];
    assign data_valid = (data_idx < IDX_W'(ROW_BYTES));
    assign next_valid = (data_idx < IDX_W'(ROW_BYTES - 1));
    assign data_addr0 = row_addr(cursor_row_reg, data_valid ? data_idx[3:0] : 4'd0);
    assign data_addr1 = next_valid ? data_addr0 + ADDR_W'(1) : data_addr0;
    assign shift      = WORD6_SHIFT_BASE - {1'b0, bitpos[2:0]};

    // Location of the queried pixel byte, with the scroll offset applied.
    logic [ROW_W-1:0]  pix_row;
    logic [3:0]        pix_idx;
    logic [ADDR_W-1:0] pix_addr;

    assign pix_row  = in_qrow + scroll_reg;
    assign pix_idx  = in_qcol[6:3];
    assign pix_addr = row_addr(pix_row, (pix_idx < 4'(ROW_BYTES)) ? pix_idx : 4'd0);

    // 6-bit word read and merge over the two fetched bytes.
    logic [15:0] word_in;
    logic [15:0] word_shifted;
    logic [15:0] word_merged;
    logic [7:0]  word6_read;

    assign word_in      = {byte0_reg, next_valid ? byte1_reg : 8'h00};
    assign word_shifted = word_in >> shift;
    assign word6_read   = {2'b00, word_shifted[5:0]};
    assign word_merged  = (word_in & ~(WORD6_MASK << shift))
                        | ({10'h000, item_value_reg[5:0]} << shift);

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'h00, out_enable_reg, out_pixel_reg, out_data_reg};

    lcdc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic for the sequencer, the controller registers and the RAM port.
    always_comb
    begin
        logic [COL_W-1:0] last_col;
        logic             do_advance;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        item_op_next    = item_op_reg;
        item_value_next = item_value_reg;
        item_qcol_next  = item_qcol_reg;
        byte0_next      = byte0_reg;
        byte1_next      = byte1_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_data_next   = wr2_data_reg;
        enable_next     = enable_reg;
        advance_next    = advance_reg;
        scroll_next     = scroll_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        dummy_next      = dummy_reg;
        byte_mode_next  = byte_mode_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_pixel_next  = out_pixel_reg;
        out_enable_next = out_enable_reg;
        ram_we          = 1'b0;
        ram_waddr       = data_addr0;
        ram_wdata       = 8'h00;
        ram_raddr       = data_addr0;
        last_col        = byte_mode_reg ? LAST_COL_BYTE : LAST_COL_WORD6;
        do_advance      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(RAM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                // The first byte is fetched as the request is taken.
                ram_raddr = (in_op == OP_PIXEL) ? pix_addr : data_addr0;
                if (s_tvalid)
                begin
                    item_op_next    = in_op;
                    item_value_next = in_value;
                    item_qcol_next  = in_qcol;
                    if (in_op == OP_WRITE || in_op == OP_READ || in_op == OP_PIXEL)
                    begin
                        state_next = S_FETCH1;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end

            S_FETCH1:
            begin
                byte0_next = ram_rdata;
                ram_raddr  = data_addr1;
                if (item_op_reg != OP_PIXEL && !byte_mode_reg)
                begin
                    state_next = S_FETCH2;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end

            S_FETCH2:
            begin
                byte1_next = ram_rdata;
                state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_data_next   = 8'h00;
                    out_pixel_next  = 1'b0;
                    case (item_op_reg)
                        OP_CMD:
                        begin
                            if (item_value_reg[7:6] == 2'b11)
                            begin
                                // Contrast setting: no effect here.
                            end
                            else if (item_value_reg[7])
                            begin
                                cursor_row_next = item_value_reg[5:0];
                                dummy_next      = 1'b1;
                            end
                            else if (item_value_reg[6])
                            begin
                                scroll_next = item_value_reg[5:0];
                            end
                            else if (item_value_reg[5])
                            begin
                                cursor_col_next = item_value_reg[4:0];
                                dummy_next      = 1'b1;
                            end
                            else if (item_value_reg[4] || item_value_reg[3])
                            begin
                                // Unsupported command: no effect.
                            end
                            else if (item_value_reg[2])
                            begin
                                advance_next = item_value_reg[1:0];
                            end
                            else if (item_value_reg[1])
                            begin
                                enable_next = item_value_reg[0];
                            end
                            else
                            begin
                                byte_mode_next = item_value_reg[0];
                            end
                        end

                        OP_WRITE:
                        begin
                            dummy_next = 1'b0;
                            do_advance = 1'b1;
                            if (data_valid)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = data_addr0;
                                ram_wdata = byte_mode_reg ? item_value_reg : word_merged[15:8];
                                // A word that ends inside the next byte needs a second write.
                                if (!byte_mode_reg && bitpos[2] && next_valid)
                                begin
                                    wr2_addr_next = data_addr1;
                                    wr2_data_next = word_merged[7:0];
                                    state_next    = S_WRITE2;
                                end
                            end
                        end

                        OP_READ:
                        begin
                            if (dummy_reg)
                            begin
                                dummy_next = 1'b0;
                            end
                            else
                            begin
                                do_advance = 1'b1;
                                if (data_valid)
                                begin
                                    out_data_next = byte_mode_reg ? byte0_reg : word6_read;
                                end
                            end
                        end

                        OP_PIXEL:
                        begin
                            if (item_qcol_reg[6:3] < 4'(ROW_BYTES))
                            begin
                                out_pixel_next = byte0_reg[~item_qcol_reg[2:0]];
                            end
                        end

                        default:
                        begin
                            // Status reads and unused codes answer zero read data and pixel bits.
                        end
                    endcase

                    // Cursor auto-advance after a write or a non-dummy read.
                    if (do_advance)
                    begin
                        case (advance_reg)
                            ADV_ROW_DEC: cursor_row_next = cursor_row_reg - ROW_W'(1);
                            ADV_ROW_INC: cursor_row_next = cursor_row_reg + ROW_W'(1);
                            ADV_COL_DEC:
                            begin
                                cursor_col_next = (cursor_col_reg == '0) ? last_col
                                                : cursor_col_reg - COL_W'(1);
                            end
                            ADV_COL_INC:
                            begin
                                cursor_col_next = (cursor_col_reg < last_col)
                                                ? cursor_col_reg + COL_W'(1) : '0;
                            end
                            default: cursor_col_next = cursor_col_reg;
                        endcase
                    end

                    out_enable_next = enable_next;
                end
            end

            S_WRITE2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr2_addr_reg;
                ram_wdata  = wr2_data_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            enable_reg     <= 1'b0;
            advance_reg    <= ADV_ROW_INC;
            scroll_reg     <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            dummy_reg      <= 1'b1;
            byte_mode_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            enable_reg     <= enable_next;
            advance_reg    <= advance_next;
            scroll_reg     <= scroll_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            dummy_reg      <= dummy_next;
            byte_mode_reg  <= byte_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_op_reg    <= item_op_next;
        item_value_reg <= item_value_next;
        item_qcol_reg  <= item_qcol_next;
        byte0_reg      <= byte0_next;
        byte1_reg      <= byte1_next;
        wr2_addr_reg   <= wr2_addr_next;
        wr2_data_reg   <= wr2_data_next;
        out_data_reg   <= out_data_next;
        out_pixel_reg  <= out_pixel_next;
        out_enable_reg <= out_enable_next;
    end

`ifndef SYNTHESIS
    // No RAM write while a request is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("RAM written while idle");

    // Every RAM write stays inside the display RAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr < ADDR_W'(RAM_DEPTH)))
        else $error("RAM write address out of range");

    // A new result appears only after a commit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_COMMIT))
        else $error("result without commit");

    // The cursor moves only at a commit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cursor_col_reg) || !$stable(cursor_row_reg) |-> $past(state_reg == S_COMMIT))
        else $error("cursor moved outside commit");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lcdc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 960
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
